[design/config_text_tokenizer_defines.svh]
// Assertion macros used by the config text tokenizer state machine RTL
`ifndef CONFIG_TEXT_TOKENIZER_DEFINES_SVH
`define CONFIG_TEXT_TOKENIZER_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define CTT_ASSERT_IMP(label, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error("tokenizer assertion failed");

// next-cycle implication
`define CTT_ASSERT_NXT(label, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error("tokenizer assertion failed");

`endif

[design/cfgtok_pkg.sv]
// Types and character constants for the config text tokenizer
`timescale 1ns / 1ps
package cfgtok_pkg;

	typedef enum logic [2:0] {
		EV_NONE   = 3'd0,
		EV_ERR    = 3'd1,
		EV_NAME   = 3'd2,
		EV_SOPEN  = 3'd3,
		EV_SCLOSE = 3'd4,
		EV_NUM    = 3'd5,
		EV_STR    = 3'd6,
		EV_BOOL   = 3'd7
	} ev_t;

	typedef struct packed {
		logic       ident;
		logic       space;
		logic       digit;
		logic [7:0] lc;
	} class_t;

	typedef struct packed {
		ev_t         ev;
		logic        app_v;
		logic [7:0]  app_b;
		logic [15:0] line;
		logic [15:0] col;
	} result_t;

	localparam logic REG_MASK_LOW  = 1'b0;
	localparam logic REG_MASK_HIGH = 1'b1;

	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_0      = 8'h30;
	localparam logic [7:0] CH_9      = 8'h39;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_UP_A   = 8'h41;
	localparam logic [7:0] CH_UP_E   = 8'h45;
	localparam logic [7:0] CH_UP_Z   = 8'h5A;
	localparam logic [7:0] CH_A      = 8'h61;
	localparam logic [7:0] CH_E      = 8'h65;
	localparam logic [7:0] CH_F      = 8'h66;
	localparam logic [7:0] CH_L      = 8'h6C;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_S      = 8'h73;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_U      = 8'h75;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CASE_OFS  = 8'h20;
	localparam logic [7:0] CH_NUL    = 8'h00;

	localparam logic [63:0] MASK_LOW_RST  = 64'h03FF_0000_0000_0000;
	localparam logic [63:0] MASK_HIGH_RST = 64'h07FF_FFFE_8000_0000;

endpackage

[design/cfgtok_class.sv]
// Byte classifier: identifier, whitespace, digit and lowercase
`timescale 1ns / 1ps
module cfgtok_class import cfgtok_pkg::*; (
	input  logic [7:0]  in_byte,
	input  logic [63:0] mask_low,
	input  logic [63:0] mask_high,
	output class_t      cls
);

	logic [127:0] mask;

	assign mask = {mask_high, mask_low};

	always_comb begin
		cls.ident = !in_byte[7] && mask[in_byte[6:0]];
		cls.space = (in_byte == CH_SPACE) || (in_byte >= CH_TAB && in_byte <= CH_CR);
		cls.digit = (in_byte >= CH_0) && (in_byte <= CH_9);
		cls.lc    = (in_byte >= CH_UP_A && in_byte <= CH_UP_Z) ? in_byte + CASE_OFS : in_byte;
	end

endmodule

[design/cfgtok_fsm.sv]
// Recognizer state machine with line and column counters
`timescale 1ns / 1ps
`include "config_text_tokenizer_defines.svh"
module cfgtok_fsm import cfgtok_pkg::*; #(
	parameter int COUNTER_WIDTH = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] in_byte,
	input  class_t     cls,
	output result_t    res
);

	typedef enum logic [4:0] {
		ST_WS       = 5'd0,
		ST_CMT1     = 5'd1,
		ST_CMT      = 5'd2,
		ST_IDENT    = 5'd3,
		ST_AFTER_ID = 5'd4,
		ST_VAL_WS   = 5'd5,
		ST_NUM      = 5'd6,
		ST_NUM_END  = 5'd7,
		ST_STR      = 5'd8,
		ST_STR_WS   = 5'd9,
		ST_T1       = 5'd10,
		ST_T2       = 5'd11,
		ST_T3       = 5'd12,
		ST_F1       = 5'd13,
		ST_F2       = 5'd14,
		ST_F3       = 5'd15,
		ST_F4       = 5'd16,
		ST_BOOL_END = 5'd17
	} state_t;

	localparam logic [COUNTER_WIDTH-1:0] CNT_ONE = COUNTER_WIDTH'(1);
	localparam logic [COUNTER_WIDTH-1:0] CNT_MAX = '1;

	state_t                   state_q, st_eff, st_nxt;
	logic [COUNTER_WIDTH-1:0] line_q, col_q, line_eff, col_eff, col_nxt;
	logic                     is_nl;
	ev_t                      ev;
	logic                     app_v;
	logic [7:0]               app_b;

	assign is_nl    = (in_byte == CH_LF);
	assign st_eff   = (is_nl && state_q == ST_CMT) ? ST_WS : state_q;
	assign line_eff = (is_nl && line_q != CNT_MAX) ? line_q + CNT_ONE : line_q;
	assign col_eff  = is_nl ? CNT_ONE : col_q;
	assign col_nxt  = (ev == EV_NONE && col_eff != CNT_MAX) ? col_eff + CNT_ONE : col_eff;

	always_comb begin
		st_nxt = st_eff;
		ev     = EV_NONE;
		app_v  = 1'b0;
		app_b  = CH_NUL;
		unique case (st_eff)
			ST_WS: begin
				priority if (cls.ident) begin
					st_nxt = ST_IDENT; app_v = 1'b1; app_b = in_byte;
				end else if (in_byte == CH_RBRACE) begin
					ev = EV_SCLOSE;
				end else if (cls.space) begin
					st_nxt = ST_WS;
				end else if (in_byte == CH_SLASH) begin
					st_nxt = ST_CMT1;
				end else begin
					ev = EV_ERR;
				end
			end
			ST_CMT1: begin
				if (in_byte == CH_SLASH) st_nxt = ST_CMT;
				else ev = EV_ERR;
			end
			ST_CMT: begin
				st_nxt = ST_CMT;
			end
			ST_IDENT: begin
				priority if (cls.ident) begin
					app_v = 1'b1; app_b = in_byte;
				end else if (cls.space) begin
					st_nxt = ST_AFTER_ID;
				end else if (in_byte == CH_EQ) begin
					st_nxt = ST_VAL_WS; ev = EV_NAME;
				end else if (in_byte == CH_LBRACE) begin
					st_nxt = ST_WS; ev = EV_SOPEN;
				end else begin
					ev = EV_ERR;
				end
			end
			ST_AFTER_ID: begin
				priority if (in_byte == CH_EQ) begin
					st_nxt = ST_VAL_WS; ev = EV_NAME;
				end else if (in_byte == CH_LBRACE) begin
					st_nxt = ST_WS; ev = EV_SOPEN;
				end else if (cls.space) begin
					st_nxt = ST_AFTER_ID;
				end else begin
					ev = EV_ERR;
				end
			end
			ST_VAL_WS: begin
				priority if (cls.space) begin
					st_nxt = ST_VAL_WS;
				end else if (cls.digit || in_byte == CH_PLUS || in_byte == CH_MINUS ||
						in_byte == CH_DOT) begin
					st_nxt = ST_NUM; app_v = 1'b1; app_b = in_byte;
				end else if (in_byte == CH_QUOTE) begin
					st_nxt = ST_STR;
				end else if (cls.lc == CH_T) begin
					st_nxt = ST_T1; app_v = 1'b1; app_b = CH_T;
				end else if (cls.lc == CH_F) begin
					st_nxt = ST_F1; app_v = 1'b1; app_b = CH_F;
				end else begin
					ev = EV_ERR;
				end
			end
			ST_NUM: begin
				priority if (cls.digit || in_byte == CH_DOT || in_byte == CH_E ||
						in_byte == CH_UP_E) begin
					app_v = 1'b1; app_b = in_byte;
				end else if (cls.space) begin
					st_nxt = ST_NUM_END;
				end else if (in_byte == CH_SEMI) begin
					st_nxt = ST_WS; ev = EV_NUM;
				end else begin
					ev = EV_ERR;
				end
			end
			ST_NUM_END: begin
				priority if (cls.space) begin
					st_nxt = ST_NUM_END;
				end else if (in_byte == CH_SEMI) begin
					st_nxt = ST_WS; ev = EV_NUM;
				end else begin
					ev = EV_ERR;
				end
			end
			ST_STR: begin
				if (in_byte == CH_QUOTE) begin
					st_nxt = ST_STR_WS;
				end else begin
					app_v = 1'b1; app_b = in_byte;
				end
			end
			ST_STR_WS: begin
				priority if (in_byte == CH_QUOTE) begin
					st_nxt = ST_STR;
				end else if (cls.space) begin
					st_nxt = ST_STR_WS;
				end else if (in_byte == CH_SEMI) begin
					st_nxt = ST_WS; ev = EV_STR; app_v = 1'b1; app_b = CH_NUL;
				end else begin
					ev = EV_ERR;
				end
			end
			ST_T1: begin
				if (cls.lc == CH_R) begin
					st_nxt = ST_T2; app_v = 1'b1; app_b = CH_R;
				end else ev = EV_ERR;
			end
			ST_T2: begin
				if (cls.lc == CH_U) begin
					st_nxt = ST_T3; app_v = 1'b1; app_b = CH_U;
				end else ev = EV_ERR;
			end
			ST_T3: begin
				if (cls.lc == CH_E) begin
					st_nxt = ST_BOOL_END; app_v = 1'b1; app_b = CH_E;
				end else ev = EV_ERR;
			end
			ST_F1: begin
				if (cls.lc == CH_A) begin
					st_nxt = ST_F2; app_v = 1'b1; app_b = CH_A;
				end else ev = EV_ERR;
			end
			ST_F2: begin
				if (cls.lc == CH_L) begin
					st_nxt = ST_F3; app_v = 1'b1; app_b = CH_L;
				end else ev = EV_ERR;
			end
			ST_F3: begin
				if (cls.lc == CH_S) begin
					st_nxt = ST_F4; app_v = 1'b1; app_b = CH_S;
				end else ev = EV_ERR;
			end
			ST_F4: begin
				if (cls.lc == CH_E) begin
					st_nxt = ST_BOOL_END; app_v = 1'b1; app_b = CH_E;
				end else ev = EV_ERR;
			end
			ST_BOOL_END: begin
				priority if (cls.space) begin
					st_nxt = ST_BOOL_END;
				end else if (in_byte == CH_SEMI) begin
					st_nxt = ST_WS; ev = EV_BOOL;
				end else begin
					ev = EV_ERR;
				end
			end
			default: begin
				st_nxt = ST_WS;
			end
		endcase
	end

	always_comb begin
		res.ev    = ev;
		res.app_v = app_v;
		res.app_b = app_b;
		res.line  = 16'(line_eff);
		res.col   = 16'(col_eff);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_WS;
			line_q  <= CNT_ONE;
			col_q   <= CNT_ONE;
		end else if (step) begin
			state_q <= st_nxt;
			line_q  <= line_eff;
			col_q   <= col_nxt;
		end
	end

	`CTT_ASSERT_IMP(a_err_no_append, step && ev == EV_ERR, !app_v && st_nxt == st_eff)
	`CTT_ASSERT_NXT(a_col_hold, step && ev != EV_NONE && !is_nl, $stable(col_q))
	`CTT_ASSERT_IMP(a_counters_nonzero, 1'b1, line_q != '0 && col_q != '0)

endmodule

[design/config_text_tokenizer.sv]
// Top level of the config text tokenizer: registers, handshake and datapath
//
//  channel  | dir | tdata                                     | tuser
//  s_axis   | in  | [7:0] in_byte                             | -
//  m_axis   | out | [7:0] append_byte [23:8] line [39:24] col | [2:0] event [3] append_valid
//  cfg      | in  | cfg_index 0: ident_mask_low, 1: ident_mask_high
//
// One byte per cycle sustained while m_tready stays high; each byte passes through the
// input register, then the state machine step into the result register.
// The state and counters update in the same cycle the result is registered.
// Reset returns to the whitespace state with line and column at one.
// A stalled output holds its result while one more byte waits in the input register.
`timescale 1ns / 1ps
module config_text_tokenizer import cfgtok_pkg::*; #(
	parameter int COUNTER_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] in_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [7:0] append_byte, [23:8] line_number, [39:24] column_number
	output logic [3:0]  m_tuser,   // [2:0] event_res, [3] append_valid
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [63:0] cfg_wdata
);

	logic [63:0] mask_low_q, mask_high_q;
	logic [7:0]  byte_s1;
	logic        valid_s1, valid_s2;
	result_t     res, res_s2;
	class_t      cls;
	logic        advance, step;

	assign advance  = !valid_s2 || m_tready;
	assign step     = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_low_q  <= MASK_LOW_RST;
			mask_high_q <= MASK_HIGH_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MASK_LOW:  mask_low_q  <= cfg_wdata;
				REG_MASK_HIGH: mask_high_q <= cfg_wdata;
				default:       mask_low_q  <= mask_low_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) valid_s1 <= 1'b1;
			else if (step)            valid_s1 <= 1'b0;
			if (step)          valid_s2 <= 1'b1;
			else if (m_tready) valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) byte_s1 <= s_tdata;
		if (step)                 res_s2  <= res;
	end

	cfgtok_class u_class (
		.in_byte   (byte_s1),
		.mask_low  (mask_low_q),
		.mask_high (mask_high_q),
		.cls       (cls)
	);

	cfgtok_fsm #(
		.COUNTER_WIDTH (COUNTER_WIDTH)
	) u_fsm (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.in_byte (byte_s1),
		.cls     (cls),
		.res     (res)
	);

	assign m_tvalid = valid_s2;
	assign m_tdata  = {res_s2.col, res_s2.line, res_s2.app_b};
	assign m_tuser  = {res_s2.app_v, res_s2.ev};

endmodule
